### rtl/ecsbs_pkg.sv
// Package for the edge counting sort block: field widths, defaults,
// controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package ecsbs_pkg;

    localparam int VERTEX_W         = 8;
    localparam int NUMV_W           = 9;
    localparam int MAX_EDGES_DEF    = 64;
    localparam int MAX_VERTICES_DEF = 256;
    localparam logic [NUMV_W-1:0] NUMV_RESET = 9'd256;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_CNT_EDGE,
        S_CNT_KEY,
        S_CNT_WR,
        S_SUM_RD,
        S_SUM_WR,
        S_PL_EDGE,
        S_PL_KEY,
        S_PL_WR,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT,
        S_CLEAR
    } ctrl_state_t;

    typedef struct packed {
        logic ptr_clr;
        logic ptr_top;
        logic ptr_inc;
        logic ptr_dec;
        logic edge_rd;
        logic key_rd;
        logic cnt_inc_wr;
        logic sum_clr;
        logic sum_rd;
        logic sum_wr;
        logic place_wr;
        logic out_rd;
        logic out_load;
        logic batch_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic ptr_last;
        logic ptr_zero;
        logic sum_done;
        logic out_fire;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/ecsbs_if.sv
// Channel interfaces of the edge counting sort block: edge input,
// sorted edge output and configuration write.
// Depends on ecsbs_pkg.
`default_nettype none

interface ecsbs_edge_in_if;
    logic                            valid;
    logic                            ready;
    logic [ecsbs_pkg::VERTEX_W-1:0]  source_vertex;
    logic [ecsbs_pkg::VERTEX_W-1:0]  dest_vertex;
    logic                            last_edge;

    modport source (output valid, output source_vertex, output dest_vertex,
                    output last_edge, input ready);
    modport sink   (input valid, input source_vertex, input dest_vertex,
                    input last_edge, output ready);
endinterface

interface ecsbs_edge_out_if;
    logic                            valid;
    logic                            ready;
    logic [ecsbs_pkg::VERTEX_W-1:0]  sorted_source;
    logic [ecsbs_pkg::VERTEX_W-1:0]  sorted_dest;
    logic                            end_of_run;
    logic                            dropped_flag;

    modport source (output valid, output sorted_source, output sorted_dest,
                    output end_of_run, output dropped_flag, input ready);
    modport sink   (input valid, input sorted_source, input sorted_dest,
                    input end_of_run, input dropped_flag, output ready);
endinterface

interface ecsbs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ecsbs_pkg::NUMV_W-1:0]    num_vertices;

    modport source (output valid, output num_vertices, input ready);
    modport sink   (input valid, input num_vertices, output ready);
endinterface

`default_nettype wire

### rtl/ecsbs_ctrl.sv
// Sequencer of the edge counting sort: load, check, count, prefix sum, place,
// emit and clear phases, driving the datapath by command struct.
// Depends on ecsbs_pkg.
`default_nettype none

module ecsbs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_last,
    output logic                       in_ready,
    input  wire ecsbs_pkg::dp_status_t status,
    output ecsbs_pkg::dp_cmd_t         cmd
);

    ecsbs_pkg::ctrl_state_t state_reg;
    ecsbs_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecsbs_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ecsbs_pkg::S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid && in_last)
                begin
                    state_next = ecsbs_pkg::S_CHECK;
                end
            end
            ecsbs_pkg::S_CHECK:
            begin
                cmd.ptr_clr = 1'b1;
                cmd.sum_clr = 1'b1;
                if (status.total_zero)
                begin
                    state_next = ecsbs_pkg::S_CLEAR;
                end
                else
                begin
                    state_next = ecsbs_pkg::S_CNT_EDGE;
                end
            end
            ecsbs_pkg::S_CNT_EDGE:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ecsbs_pkg::S_CNT_KEY;
            end
            ecsbs_pkg::S_CNT_KEY:
            begin
                cmd.key_rd = 1'b1;
                state_next = ecsbs_pkg::S_CNT_WR;
            end
            ecsbs_pkg::S_CNT_WR:
            begin
                cmd.cnt_inc_wr = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = ecsbs_pkg::S_SUM_RD;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ecsbs_pkg::S_CNT_EDGE;
                end
            end
            ecsbs_pkg::S_SUM_RD:
            begin
                cmd.sum_rd = 1'b1;
                state_next = ecsbs_pkg::S_SUM_WR;
            end
            ecsbs_pkg::S_SUM_WR:
            begin
                cmd.sum_wr = 1'b1;
                if (status.sum_done)
                begin
                    cmd.ptr_top = 1'b1;
                    state_next  = ecsbs_pkg::S_PL_EDGE;
                end
                else
                begin
                    state_next = ecsbs_pkg::S_SUM_RD;
                end
            end
            ecsbs_pkg::S_PL_EDGE:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ecsbs_pkg::S_PL_KEY;
            end
            ecsbs_pkg::S_PL_KEY:
            begin
                cmd.key_rd = 1'b1;
                state_next = ecsbs_pkg::S_PL_WR;
            end
            ecsbs_pkg::S_PL_WR:
            begin
                cmd.place_wr = 1'b1;
                if (status.ptr_zero)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ecsbs_pkg::S_EM_RD;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = ecsbs_pkg::S_PL_EDGE;
                end
            end
            ecsbs_pkg::S_EM_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ecsbs_pkg::S_EM_LD;
            end
            ecsbs_pkg::S_EM_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ecsbs_pkg::S_EM_WAIT;
            end
            ecsbs_pkg::S_EM_WAIT:
            begin
                if (status.out_fire)
                begin
                    if (status.ptr_last)
                    begin
                        state_next = ecsbs_pkg::S_CLEAR;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = ecsbs_pkg::S_EM_RD;
                    end
                end
            end
            ecsbs_pkg::S_CLEAR:
            begin
                cmd.batch_clr = 1'b1;
                state_next    = ecsbs_pkg::S_LOAD;
            end
            default:
            begin
                state_next = ecsbs_pkg::S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ecsbs_datapath.sv
// Datapath of the edge counting sort: edge store, key histogram with
// per-key valid bits, sorted store, pointers, config and output register.
// Depends on ecsbs_pkg.
`default_nettype none

module ecsbs_datapath #(
    parameter int MAX_EDGES    = ecsbs_pkg::MAX_EDGES_DEF,
    parameter int MAX_VERTICES = ecsbs_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_fire,
    input  wire logic [ecsbs_pkg::VERTEX_W-1:0]   in_src,
    input  wire logic [ecsbs_pkg::VERTEX_W-1:0]   in_dst,
    input  wire logic                             cfg_fire,
    input  wire logic [ecsbs_pkg::NUMV_W-1:0]     cfg_data,
    input  wire ecsbs_pkg::dp_cmd_t               cmd,
    output ecsbs_pkg::dp_status_t                 status,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ecsbs_pkg::VERTEX_W-1:0]        out_src,
    output logic [ecsbs_pkg::VERTEX_W-1:0]        out_dst,
    output logic                                  out_end,
    output logic                                  out_drop
);

    localparam int VW     = ecsbs_pkg::VERTEX_W;
    localparam int EDGE_W = 2 * VW;
    localparam int IDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int KEYS   = (MAX_VERTICES < (1 << VW)) ? MAX_VERTICES : (1 << VW);
    localparam int KEY_W  = $clog2(KEYS);

    // stores
    logic [EDGE_W-1:0] edge_store_reg   [MAX_EDGES];
    logic [EDGE_W-1:0] sorted_store_reg [MAX_EDGES];
    logic [CNT_W-1:0]  key_counts_reg   [KEYS];

    logic [KEYS-1:0]   cnt_vld_reg,  cnt_vld_next;
    logic [ecsbs_pkg::NUMV_W-1:0] numv_reg, numv_next;
    logic [CNT_W-1:0]  total_reg,    total_next;
    logic              drop_reg,     drop_next;
    logic [IDX_W-1:0]  ptr_reg,      ptr_next;
    logic [KEY_W-1:0]  sum_k_reg,    sum_k_next;
    logic [CNT_W-1:0]  run_reg,      run_next;
    logic              out_valid_reg, out_valid_next;

    logic [EDGE_W-1:0] edge_q_reg;
    logic [EDGE_W-1:0] sorted_q_reg;
    logic [CNT_W-1:0]  cnt_q_reg;
    logic              cnt_vq_reg;
    logic [VW-1:0]     out_src_reg;
    logic [VW-1:0]     out_dst_reg;
    logic              out_end_reg;
    logic              out_drop_reg;

    logic              src_ok;
    logic              room;
    logic              keep;
    logic [KEY_W-1:0]  edge_key;
    logic [KEY_W-1:0]  cnt_raddr;
    logic [KEY_W-1:0]  cnt_waddr;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_val;
    logic [CNT_W-1:0]  slot;
    logic              ptr_last;
    logic              out_fire;

    assign src_ok = ({1'b0, in_src} < numv_reg)
                 && ({{(32 - VW){1'b0}}, in_src} < 32'(MAX_VERTICES));
    assign room   = total_reg < CNT_W'(MAX_EDGES);
    assign keep   = in_fire && src_ok && room;

    assign edge_key  = edge_q_reg[VW +: KEY_W];
    assign cnt_raddr = cmd.sum_rd ? sum_k_reg : edge_key;
    assign cnt_val   = cnt_vq_reg ? cnt_q_reg : '0;
    assign slot      = cnt_val - CNT_W'(1);
    assign run_next  = cmd.sum_clr ? '0 : (cmd.sum_wr ? run_reg + cnt_val : run_reg);

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = edge_key;
        cnt_wdata = cnt_val + CNT_W'(1);
        priority if (cmd.cnt_inc_wr)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.sum_wr)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = sum_k_reg;
            cnt_wdata = run_reg + cnt_val;
        end
        else if (cmd.place_wr)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = slot;
        end
    end

    // edge, histogram and sorted stores
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            edge_store_reg[total_reg[IDX_W-1:0]] <= {in_src, in_dst};
        end
        if (cmd.edge_rd)
        begin
            edge_q_reg <= edge_store_reg[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_rd || cmd.sum_rd)
        begin
            cnt_q_reg  <= key_counts_reg[cnt_raddr];
            cnt_vq_reg <= cnt_vld_reg[cnt_raddr];
        end
        if (cnt_we)
        begin
            key_counts_reg[cnt_waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.place_wr)
        begin
            sorted_store_reg[slot[IDX_W-1:0]] <= edge_q_reg;
        end
        if (cmd.out_rd)
        begin
            sorted_q_reg <= sorted_store_reg[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_src_reg  <= sorted_q_reg[EDGE_W-1 -: VW];
            out_dst_reg  <= sorted_q_reg[VW-1:0];
            out_end_reg  <= ptr_last;
            out_drop_reg <= drop_reg;
        end
    end

    assign ptr_last = (CNT_W'(ptr_reg) + CNT_W'(1)) == total_reg;
    assign out_fire = out_valid_reg && out_ready;

    always_comb
    begin
        cnt_vld_next = cnt_vld_reg;
        if (cmd.batch_clr)
        begin
            cnt_vld_next = '0;
        end
        else if (cnt_we)
        begin
            cnt_vld_next[cnt_waddr] = 1'b1;
        end

        numv_next = cfg_fire ? cfg_data : numv_reg;

        total_next = total_reg;
        drop_next  = drop_reg;
        if (cmd.batch_clr)
        begin
            total_next = '0;
            drop_next  = 1'b0;
        end
        else if (in_fire)
        begin
            if (keep)
            begin
                total_next = total_reg + CNT_W'(1);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        ptr_next = ptr_reg;
        priority if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_top)
        begin
            ptr_next = IDX_W'(total_reg - CNT_W'(1));
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + IDX_W'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - IDX_W'(1);
        end

        sum_k_next = sum_k_reg;
        if (cmd.sum_clr)
        begin
            sum_k_next = '0;
        end
        else if (cmd.sum_wr)
        begin
            sum_k_next = sum_k_reg + KEY_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg   <= '0;
            numv_reg      <= ecsbs_pkg::NUMV_RESET;
            total_reg     <= '0;
            drop_reg      <= 1'b0;
            ptr_reg       <= '0;
            sum_k_reg     <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_vld_reg   <= cnt_vld_next;
            numv_reg      <= numv_next;
            total_reg     <= total_next;
            drop_reg      <= drop_next;
            ptr_reg       <= ptr_next;
            sum_k_reg     <= sum_k_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.total_zero = total_reg == '0;
    assign status.ptr_last   = ptr_last;
    assign status.ptr_zero   = ptr_reg == '0;
    assign status.sum_done   = sum_k_reg == KEY_W'(KEYS - 1);
    assign status.out_fire   = out_fire;

    assign out_valid = out_valid_reg;
    assign out_src   = out_src_reg;
    assign out_dst   = out_dst_reg;
    assign out_end   = out_end_reg;
    assign out_drop  = out_drop_reg;

endmodule

`default_nettype wire

### rtl/edge_counting_sort_by_source.sv
// Top level of the edge counting sort block.
// Depends on ecsbs_pkg, ecsbs_if, ecsbs_ctrl and ecsbs_datapath.
//
// Stable counting sort of graph edges by source vertex. Edges are taken one
// request per cycle while loading; an edge whose source is not below
// num_vertices (or MAX_VERTICES), or that arrives with MAX_EDGES already
// held, is dropped and sets dropped_flag on every result of the batch. The
// request marked last_edge closes the batch: input is then held off while a
// single histogram memory is walked for counting, running sum and placement.
// With K = min(MAX_VERTICES, 256), an empty batch check comes first; counting
// walks the held edges, the running sum the K keys and placement the edges
// backwards, then each sorted edge waits until taken; then the batch clears.
// An empty batch gives no results.
// num_vertices may be written at any time the block is idle.
`default_nettype none

module edge_counting_sort_by_source #(
    parameter int MAX_EDGES    = ecsbs_pkg::MAX_EDGES_DEF,
    parameter int MAX_VERTICES = ecsbs_pkg::MAX_VERTICES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ecsbs_edge_in_if.sink   edges_in,
    ecsbs_edge_out_if.source edges_out,
    ecsbs_cfg_if.sink       cfg
);

    ecsbs_pkg::dp_cmd_t    cmd;
    ecsbs_pkg::dp_status_t status;
    logic                  in_ready;
    logic                  in_fire;
    logic                  cfg_fire;

    assign edges_in.ready = in_ready;
    assign in_fire        = edges_in.valid && in_ready;
    assign cfg.ready      = 1'b1;
    assign cfg_fire       = cfg.valid;

    ecsbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges_in.valid),
        .in_last  (edges_in.last_edge),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ecsbs_datapath #(
        .MAX_EDGES    (MAX_EDGES),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_src    (edges_in.source_vertex),
        .in_dst    (edges_in.dest_vertex),
        .cfg_fire  (cfg_fire),
        .cfg_data  (cfg.num_vertices),
        .cmd       (cmd),
        .status    (status),
        .out_valid (edges_out.valid),
        .out_ready (edges_out.ready),
        .out_src   (edges_out.sorted_source),
        .out_dst   (edges_out.sorted_dest),
        .out_end   (edges_out.end_of_run),
        .out_drop  (edges_out.dropped_flag)
    );

endmodule

`default_nettype wire

### rtl/ecsbs_checker.sv
// Port-level checks for the edge counting sort block, bound to the top.
// Depends on edge_counting_sort_by_source and ecsbs_pkg.
`default_nettype none

module ecsbs_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           in_last,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [ecsbs_pkg::VERTEX_W-1:0] out_src,
    input wire logic [ecsbs_pkg::VERTEX_W-1:0] out_dst,
    input wire logic                           out_end,
    input wire logic                           out_drop
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_src) && $stable(out_dst)
                                    && $stable(out_end) && $stable(out_drop))
        else $error("stalled result changed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still taken after the closing request");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_end |=> !out_valid)
        else $error("result offered after end of run");

endmodule

bind edge_counting_sort_by_source ecsbs_checker u_ecsbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (edges_in.valid),
    .in_ready  (edges_in.ready),
    .in_last   (edges_in.last_edge),
    .out_valid (edges_out.valid),
    .out_ready (edges_out.ready),
    .out_src   (edges_out.sorted_source),
    .out_dst   (edges_out.sorted_dest),
    .out_end   (edges_out.end_of_run),
    .out_drop  (edges_out.dropped_flag)
);

`default_nettype wire

### tb/tb_edge_counting_sort_by_source.sv
// Self-checking testbench for edge_counting_sort_by_source: batches of edges
// are sent, sorted by source in a local predictor and checked on the output.
// Depends on ecsbs_pkg, ecsbs_if and the RTL top level.
`default_nettype none

module tb_edge_counting_sort_by_source;

    localparam int VW            = ecsbs_pkg::VERTEX_W;
    localparam int NW            = ecsbs_pkg::NUMV_W;
    localparam int MAX_E         = ecsbs_pkg::MAX_EDGES_DEF;
    localparam int MAX_V         = ecsbs_pkg::MAX_VERTICES_DEF;
    localparam int DRAIN_CYCLES  = 600;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 100;

    typedef struct packed {
        logic [VW-1:0] src;
        logic [VW-1:0] dst;
        logic          eor;
        logic          dropped;
    } sorted_edge_t;

    logic clk;
    logic rst_n;

    ecsbs_edge_in_if  edge_in ();
    ecsbs_edge_out_if edge_out ();
    ecsbs_cfg_if      cfg_wr ();

    edge_counting_sort_by_source u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .edges_in  (edge_in),
        .edges_out (edge_out),
        .cfg       (cfg_wr)
    );

    // predictor state
    logic [2*VW-1:0]       held_edges [MAX_E];
    int unsigned           key_tally  [MAX_V];
    int unsigned           edges_held;
    bit                    batch_dropped;
    logic [NW-1:0]         numv_model;

    sorted_edge_t sorted_edges_due [$];

    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          source_gaps_on;
    bit          sink_stalls_on;

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic void clear_sort_batch();
        for (int k = 0; k < MAX_V; k++)
            key_tally[k] = 0;
        edges_held    = 0;
        batch_dropped = 0;
    endfunction

    // stable counting sort of the held batch, results queued in output order
    function automatic void sort_and_queue();
        logic [2*VW-1:0]       placed [MAX_E];
        sorted_edge_t          r;
        int unsigned           run;
        int unsigned           key;
        int unsigned           slot;
        run = 0;
        for (int k = 0; k < MAX_V; k++)
        begin
            run          += key_tally[k];
            key_tally[k]  = run;
        end
        for (int i = int'(edges_held) - 1; i >= 0; i--)
        begin
            key            = held_edges[i][2*VW-1:VW];
            slot           = key_tally[key] - 1;
            placed[slot]   = held_edges[i];
            key_tally[key] = slot;
        end
        for (int i = 0; i < int'(edges_held); i++)
        begin
            r.src     = placed[i][2*VW-1:VW];
            r.dst     = placed[i][VW-1:0];
            r.eor     = (i + 1 == int'(edges_held));
            r.dropped = batch_dropped;
            sorted_edges_due.push_back(r);
        end
    endfunction

    function automatic void absorb_edge(input logic [VW-1:0] s,
                                        input logic [VW-1:0] d,
                                        input logic last);
        if (edges_held >= MAX_E || s >= numv_model)
            batch_dropped = 1;
        else
        begin
            held_edges[edges_held] = {s, d};
            key_tally[s]++;
            edges_held++;
        end
        if (last)
        begin
            sort_and_queue();
            clear_sort_batch();
        end
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_edge(input logic [VW-1:0] s,
                             input logic [VW-1:0] d,
                             input logic last);
        int unsigned gap;
        gap = 0;
        if (source_gaps_on && $urandom_range(0, 9) < 3)
            gap = pick_gap();
        if (gap > 0)
        begin
            edge_in.valid = 0;
            repeat (gap) @(negedge clk);
        end
        edge_in.valid         = 1;
        edge_in.source_vertex = s;
        edge_in.dest_vertex   = d;
        edge_in.last_edge     = last;
        @(posedge clk);
        while (!edge_in.ready)
            @(posedge clk);
        absorb_edge(s, d, last);
        @(negedge clk);
        if (last)
            edge_in.valid = 0;
    endtask

    task automatic wait_drained();
        while (sorted_edges_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_num_vertices(input logic [NW-1:0] v);
        wait_drained();
        cfg_wr.valid        = 1;
        cfg_wr.num_vertices = v;
        @(posedge clk);
        while (!cfg_wr.ready)
            @(posedge clk);
        numv_model = v;
        @(negedge clk);
        cfg_wr.valid = 0;
    endtask

    task automatic test_edge_extremes();
        source_gaps_on = 1;
        sink_stalls_on = 1;
        send_edge(8'd255, 8'd0,   0);
        send_edge(8'd0,   8'd255, 0);
        send_edge(8'd7,   8'd1,   0);
        send_edge(8'd7,   8'd2,   0);
        send_edge(8'd0,   8'd3,   0);
        send_edge(8'd255, 8'd255, 1);
        send_edge(8'd0,   8'd0,   1);
    endtask

    task automatic test_bad_source();
        write_num_vertices(9'd1);
        send_edge(8'd0,   8'd10, 0);
        send_edge(8'd1,   8'd11, 0);
        send_edge(8'd0,   8'd12, 1);
        // nothing accepted: empty batch, drop state still cleared
        send_edge(8'd200, 8'd5,  1);
        send_edge(8'd0,   8'd9,  1);
    endtask

    task automatic test_register_extremes();
        write_num_vertices(9'd0);
        send_edge(8'd0,   8'd1, 0);
        send_edge(8'd5,   8'd2, 1);
        write_num_vertices(9'd511);
        send_edge(8'd255, 8'd4, 0);
        send_edge(8'd128, 8'd8, 1);
        write_num_vertices(9'd256);
    endtask

    task automatic test_store_full();
        source_gaps_on = 0;
        sink_stalls_on = 0;
        for (int i = 0; i < MAX_E; i++)
            send_edge(8'($urandom_range(0, 7)), 8'($urandom), i == MAX_E - 1);
        sink_stalls_on = 1;
        for (int i = 0; i < MAX_E + 2; i++)
            send_edge(8'($urandom_range(0, 7)), 8'($urandom), i == MAX_E + 1);
    endtask

    task automatic test_random_batches(input int unsigned budget);
        int unsigned sent;
        int unsigned size;
        int unsigned lim;
        int unsigned sel;
        logic [VW-1:0] pool [3];
        logic [VW-1:0] s;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                sel = $urandom_range(0, 19);
                case (sel)
                    0:       write_num_vertices(9'd0);
                    1:       write_num_vertices(9'd511);
                    2:       write_num_vertices(9'($urandom_range(257, 510)));
                    3:       write_num_vertices(9'd1);
                    4:       write_num_vertices(9'd256);
                    default: write_num_vertices(9'($urandom_range(2, 256)));
                endcase
            end
            source_gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 19);
            if (sel < 16)
                size = $urandom_range(1, 12);
            else if (sel < 19)
                size = $urandom_range(13, 40);
            else
                size = $urandom_range(60, 70);
            lim = (numv_model > MAX_V) ? MAX_V : numv_model;
            for (int k = 0; k < 3; k++)
                pool[k] = (lim == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
            for (int i = 0; i < int'(size); i++)
            begin
                sel = $urandom_range(0, 19);
                if (lim == 0 || sel < 2)
                    s = 8'($urandom);
                else if (sel < 10)
                    s = pool[$urandom_range(0, 2)];
                else
                    s = 8'($urandom_range(0, lim - 1));
                send_edge(s, 8'($urandom), i == int'(size) - 1);
            end
            sent += size;
        end
    endtask

    initial
    begin
        clk                   = 0;
        rst_n                 = 0;
        edge_in.valid         = 0;
        edge_in.source_vertex = '0;
        edge_in.dest_vertex   = '0;
        edge_in.last_edge     = 0;
        edge_out.ready        = 0;
        cfg_wr.valid          = 0;
        cfg_wr.num_vertices   = '0;
        mismatches            = 0;
        source_gaps_on        = 0;
        sink_stalls_on        = 0;
        numv_model            = ecsbs_pkg::NUMV_RESET;
        clear_sort_batch();
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        test_edge_extremes();
        test_bad_source();
        test_register_extremes();
        test_store_full();
        test_random_batches(RANDOM_ITEMS);

        wait_drained();
        if (sorted_edges_due.size() != 0)
            report_mismatch("results left over", 0, sorted_edges_due.size());
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // output side back-pressure
    initial
    begin
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!sink_stalls_on)
                edge_out.ready = 1;
            else if (hold > 0)
            begin
                edge_out.ready = 0;
                hold--;
            end
            else
            begin
                edge_out.ready = 1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        sorted_edge_t want;
        if (rst_n && edge_out.valid && edge_out.ready)
        begin
            if (sorted_edges_due.size() == 0)
                report_mismatch("unexpected result, source", edge_out.sorted_source, 0);
            else
            begin
                want = sorted_edges_due.pop_front();
                if (edge_out.sorted_source !== want.src)
                    report_mismatch("sorted_source", edge_out.sorted_source, want.src);
                if (edge_out.sorted_dest !== want.dst)
                    report_mismatch("sorted_dest", edge_out.sorted_dest, want.dst);
                if (edge_out.end_of_run !== want.eor)
                    report_mismatch("end_of_run", edge_out.end_of_run, want.eor);
                if (edge_out.dropped_flag !== want.dropped)
                    report_mismatch("dropped_flag", edge_out.dropped_flag, want.dropped);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((edge_in.valid && edge_in.ready) || (edge_out.valid && edge_out.ready)
            || (cfg_wr.valid && cfg_wr.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
